/* sv/rcoe_pkg.sv */
// shared types, constants and helpers of the rc output word encoder
package rcoe_pkg;

    localparam int CHANNEL_COUNT        = 6;
    localparam int ZERO_THROTTLE_OFFSET = 48;
    localparam int CH_IDX_W             = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int MASK_W               = 2 * CHANNEL_COUNT;
    localparam int FIFO_DEPTH           = 4;
    localparam int FIFO_PTR_W           = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W           = $clog2(FIFO_DEPTH + 1);

    localparam int CHANNEL_W = 3;
    localparam int WIDTH_W   = 15;
    localparam int MODES_W   = 12;
    localparam int TELEM_W   = 6;

    // request codes
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_CORK  = 2'd1;
    localparam logic [1:0] REQ_PUSH  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_CHANNEL_MODES = 2'd0;
    localparam logic [1:0] CFG_TELEM_MASK    = 2'd1;

    typedef enum logic [1:0] {
        MODE_PWM        = 2'd0,
        MODE_ONESHOT    = 2'd1,
        MODE_ONESHOT125 = 2'd2,
        MODE_DSHOT      = 2'd3
    } mode_t;

    // one channel to encode, as passed from front to back
    typedef struct packed {
        logic [CHANNEL_W-1:0] ch;
        logic [WIDTH_W-1:0]   width;
        logic                 last;
    } job_t;

    typedef struct packed {
        logic busy;
        logic held;
    } front_status_t;

    function automatic mode_t mode_of(input logic [MODES_W-1:0] modes,
                                      input logic [CHANNEL_W-1:0] ch);
        logic [MODES_W-1:0] shifted;
        shifted = modes >> {ch, 1'b0};
        return mode_t'(shifted[1:0]);
    endfunction

endpackage

/* sv/rcoe_front.sv */
// front end: takes requests, keeps channel widths and sequences push flushes
module rcoe_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_req_type,
    input  logic [rcoe_pkg::CHANNEL_W-1:0] s_channel,
    input  logic [rcoe_pkg::WIDTH_W-1:0]  s_pulse_us,
    input  logic [rcoe_pkg::MODES_W-1:0]  modes,
    input  logic                          q_full,
    output logic                          q_push,
    output rcoe_pkg::job_t                q_job,
    output rcoe_pkg::front_status_t       status
);

    logic [rcoe_pkg::WIDTH_W-1:0] pending_reg [rcoe_pkg::CHANNEL_COUNT];
    logic [rcoe_pkg::WIDTH_W-1:0] pending_next[rcoe_pkg::CHANNEL_COUNT];
    logic [rcoe_pkg::WIDTH_W-1:0] sent_reg    [rcoe_pkg::CHANNEL_COUNT];
    logic [rcoe_pkg::WIDTH_W-1:0] sent_next   [rcoe_pkg::CHANNEL_COUNT];
    logic                         held_reg, held_next;
    logic [rcoe_pkg::MASK_W-1:0]  mask_reg, mask_next;

    logic                          pick_found;
    logic [rcoe_pkg::MASK_W-1:0]   pick_bit;
    logic [rcoe_pkg::CHANNEL_W-1:0] pick_ch;
    logic [rcoe_pkg::MASK_W-1:0]   push_mask;
    logic                          accept;

    assign s_ready = (mask_reg == '0) && !q_full;
    assign accept  = s_valid && s_ready;
    assign status  = '{busy: (mask_reg != '0), held: held_reg};

    // lowest pending slot: pwm pass first, pulse-engine pass after
    always_comb begin
        pick_found = 1'b0;
        pick_bit   = '0;
        pick_ch    = '0;
        for (int i = 0; i < rcoe_pkg::MASK_W; i++) begin
            if (!pick_found && mask_reg[i]) begin
                pick_found = 1'b1;
                pick_bit   = rcoe_pkg::MASK_W'(1) << i;
                pick_ch    = (i < rcoe_pkg::CHANNEL_COUNT) ?
                             rcoe_pkg::CHANNEL_W'(i) :
                             rcoe_pkg::CHANNEL_W'(i - rcoe_pkg::CHANNEL_COUNT);
            end
        end
    end

    always_comb begin
        for (int c = 0; c < rcoe_pkg::CHANNEL_COUNT; c++) begin
            push_mask[c] = (rcoe_pkg::mode_of(modes, rcoe_pkg::CHANNEL_W'(c))
                            == rcoe_pkg::MODE_PWM) && (pending_reg[c] != sent_reg[c]);
            push_mask[rcoe_pkg::CHANNEL_COUNT + c] =
                rcoe_pkg::mode_of(modes, rcoe_pkg::CHANNEL_W'(c)) != rcoe_pkg::MODE_PWM;
        end
    end

    always_comb begin
        pending_next = pending_reg;
        sent_next    = sent_reg;
        held_next    = held_reg;
        mask_next    = mask_reg;
        q_push       = 1'b0;
        q_job        = '0;
        if (mask_reg != '0) begin
            if (!q_full) begin
                q_push      = 1'b1;
                q_job.ch    = pick_ch;
                q_job.width = pending_reg[pick_ch[rcoe_pkg::CH_IDX_W-1:0]];
                q_job.last  = (mask_reg & ~pick_bit) == '0;
                sent_next[pick_ch[rcoe_pkg::CH_IDX_W-1:0]] =
                    pending_reg[pick_ch[rcoe_pkg::CH_IDX_W-1:0]];
                mask_next   = mask_reg & ~pick_bit;
            end
        end else if (accept) begin
            unique case (s_req_type)
                rcoe_pkg::REQ_WRITE: begin
                    if (s_channel < rcoe_pkg::CHANNEL_W'(rcoe_pkg::CHANNEL_COUNT)) begin
                        pending_next[s_channel[rcoe_pkg::CH_IDX_W-1:0]] = s_pulse_us;
                        if (!held_reg) begin
                            sent_next[s_channel[rcoe_pkg::CH_IDX_W-1:0]] = s_pulse_us;
                            q_push      = 1'b1;
                            q_job.ch    = s_channel;
                            q_job.width = s_pulse_us;
                            q_job.last  = 1'b1;
                        end
                    end
                end
                rcoe_pkg::REQ_CORK: begin
                    held_next = 1'b1;
                end
                rcoe_pkg::REQ_PUSH: begin
                    if (held_reg) begin
                        mask_next = push_mask;
                        held_next = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= 1'b0;
            mask_reg <= '0;
            for (int c = 0; c < rcoe_pkg::CHANNEL_COUNT; c++) begin
                pending_reg[c] <= '0;
                sent_reg[c]    <= '0;
            end
        end else begin
            held_reg    <= held_next;
            mask_reg    <= mask_next;
            pending_reg <= pending_next;
            sent_reg    <= sent_next;
        end
    end

endmodule

/* sv/rcoe_fifo.sv */
// short job queue between front and back
module rcoe_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  rcoe_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output rcoe_pkg::job_t head_job
);

    rcoe_pkg::job_t                  mem [rcoe_pkg::FIFO_DEPTH];
    logic [rcoe_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [rcoe_pkg::FIFO_CNT_W-1:0] count_reg;
    logic                            do_push, do_pop;

    assign full       = count_reg == rcoe_pkg::FIFO_CNT_W'(rcoe_pkg::FIFO_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_job   = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* sv/rcoe_back.sv */
// back end: encodes one channel per cycle into the output register unless m_ready stalls it
module rcoe_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [rcoe_pkg::MODES_W-1:0]   modes,
    input  logic [rcoe_pkg::TELEM_W-1:0]   telem,
    input  logic                           head_valid,
    input  rcoe_pkg::job_t                 head_job,
    output logic                           pop,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [rcoe_pkg::CHANNEL_W-1:0] m_out_channel,
    output logic                           m_out_kind,
    output logic [31:0]                    m_out_word,
    output logic                           m_last
);

    logic                           valid_reg;
    logic [rcoe_pkg::CHANNEL_W-1:0] ch_reg;
    logic                           kind_reg;
    logic [31:0]                    word_reg;
    logic                           last_reg;

    rcoe_pkg::mode_t mode;
    logic [31:0]     word_next;
    logic            kind_next;

    // dshot path
    logic [10:0] thr;
    logic [9:0]  thr_off;
    logic [10:0] val;
    logic [11:0] pkt;
    logic [3:0]  csum;
    // oneshot path
    logic [rcoe_pkg::WIDTH_W-1:0] os_w;
    logic [15:0]                  ticks;

    assign pop  = head_valid && (!valid_reg || m_ready);
    assign mode = rcoe_pkg::mode_of(modes, head_job.ch);

    always_comb begin
        thr     = (head_job.width > 15'd2000) ? 11'd2000 : head_job.width[10:0];
        thr_off = 10'(thr - 11'd1000);
        val     = '0;
        if (thr >= 11'd1000) begin
            val = {thr_off, 1'b0};
            if (val > 11'd1999) begin
                val = 11'd1999;
            end
        end
        if (val != '0) begin
            val = val + 11'(rcoe_pkg::ZERO_THROTTLE_OFFSET);
        end
        pkt  = {val, telem[head_job.ch]};
        csum = pkt[3:0] ^ pkt[7:4] ^ pkt[11:8];

        os_w = (mode == rcoe_pkg::MODE_ONESHOT125) ? (head_job.width >> 3) : head_job.width;
        if (mode == rcoe_pkg::MODE_ONESHOT125 && os_w == '0) begin
            os_w = rcoe_pkg::WIDTH_W'(1);
        end
        ticks = {os_w, 1'b0};

        unique case (mode)
            rcoe_pkg::MODE_PWM: begin
                word_next = 32'({head_job.width, 1'b0});
                kind_next = 1'b0;
            end
            rcoe_pkg::MODE_DSHOT: begin
                word_next = {pkt, csum, 16'h0000};
                kind_next = 1'b1;
            end
            rcoe_pkg::MODE_ONESHOT, rcoe_pkg::MODE_ONESHOT125: begin
                word_next = (ticks > 16'd2) ? 32'(ticks - 16'd2) : 32'd0;
                kind_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            ch_reg   <= head_job.ch;
            kind_reg <= kind_next;
            word_reg <= word_next;
            last_reg <= head_job.last;
        end
    end

    assign m_valid       = valid_reg;
    assign m_out_channel = ch_reg;
    assign m_out_kind    = kind_reg;
    assign m_out_word    = word_reg;
    assign m_last        = last_reg;

endmodule

/* sv/rc_output_word_encoder_top.sv */
// top level of the rc output word encoder: config registers, front, queue and back
// a write that is not held is stored in the job queue and then in the output register
//   before m_valid rises
// throughput: one write per cycle while no push is being walked and the four-entry job queue
//   has room; after an accepted push the front emits one job per picked channel (up to 6)
// the back encoder retires one result per cycle into the output register unless m_ready stalls it
// reset: synchronous active-low aresetn clears widths, hold, queue and config; no clearing pass
module rc_output_word_encoder_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration writes
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [rcoe_pkg::MODES_W-1:0]   cfg_wdata,
    // request channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_req_type,
    input  logic [rcoe_pkg::CHANNEL_W-1:0] s_channel,
    input  logic [rcoe_pkg::WIDTH_W-1:0]   s_pulse_us,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [rcoe_pkg::CHANNEL_W-1:0] m_out_channel,
    output logic                           m_out_kind,
    output logic [31:0]                    m_out_word,
    output logic                           m_last
);

    // channel modes and telemetry request bits
    logic [rcoe_pkg::MODES_W-1:0] modes_reg;
    logic [rcoe_pkg::TELEM_W-1:0] telem_reg;

    // front to queue
    logic                    q_push;
    logic                    q_full;
    rcoe_pkg::job_t          q_job;
    rcoe_pkg::front_status_t front_status;

    // queue to back
    logic                    q_pop;
    logic                    q_head_valid;
    rcoe_pkg::job_t          q_head_job;

    // writes beyond the register list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modes_reg <= '0;
            telem_reg <= '0;
        end else if (cfg_we) begin
            if (cfg_index == rcoe_pkg::CFG_CHANNEL_MODES) begin
                modes_reg <= cfg_wdata;
            end else if (cfg_index == rcoe_pkg::CFG_TELEM_MASK) begin
                telem_reg <= cfg_wdata[rcoe_pkg::TELEM_W-1:0];
            end
        end
    end

    // front: classifies each transfer, walks channels on a push
    rcoe_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .s_channel  (s_channel),
        .s_pulse_us (s_pulse_us),
        .modes      (modes_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_job      (q_job),
        .status     (front_status)
    );

    // queue lets front and back stall independently
    rcoe_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (q_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_job   (q_head_job)
    );

    // back: word encoding and output register
    rcoe_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .modes         (modes_reg),
        .telem         (telem_reg),
        .head_valid    (q_head_valid),
        .head_job      (q_head_job),
        .pop           (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_channel (m_out_channel),
        .m_out_kind    (m_out_kind),
        .m_out_word    (m_out_word),
        .m_last        (m_last)
    );

    // the front never offers a job to a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_push && q_full))
        else $error("job offered to full queue");

    // no new transfer while a push is still being walked
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        front_status.busy |-> !s_ready)
        else $error("request taken during push walk");

    // a push transfer always releases the hold
    a_push_uncorks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_req_type == rcoe_pkg::REQ_PUSH) |=> !front_status.held)
        else $error("hold not released by push");

    // result kind follows the channel mode
    a_kind_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_out_kind ==
            (rcoe_pkg::mode_of(modes_reg, m_out_channel) != rcoe_pkg::MODE_PWM)))
        else $error("result kind does not match channel mode");

endmodule
